FILE: hw/rtl/swlap_pkg.sv
// Shared types, command codes and limits for the stopwatch with lap ring.
package swlap_pkg;

  localparam int KIND_W  = 3;
  localparam int DEPTH_W = 4;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int LAP_DEPTH_DEF = 9;

  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOGGLE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLR_ALL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STORE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RECALL   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_LAPS = 3'd5;

  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } time_t;

  // One-hot decoded command, each bit already qualified by the pipeline step.
  typedef struct packed {
    logic tick;
    logic toggle;
    logic clr_all;
    logic store;
    logic recall;
    logic clr_laps;
  } cmd_t;

endpackage

FILE: hw/rtl/swlap_if.sv
// Valid/ready channel interfaces for the command and time words.
interface swlap_in_if;
  logic                         valid;
  logic                         ready;
  logic [swlap_pkg::KIND_W-1:0]  kind;
  logic [swlap_pkg::DEPTH_W-1:0] recall_depth;

  modport source (output valid, output kind, output recall_depth, input ready);
  modport sink   (input valid, input kind, input recall_depth, output ready);
endinterface

interface swlap_out_if;
  logic                        valid;
  logic                        ready;
  logic [swlap_pkg::HOUR_W-1:0] hours;
  logic [swlap_pkg::MIN_W-1:0]  minutes;
  logic [swlap_pkg::SEC_W-1:0]  seconds;
  logic                        running;

  modport source (output valid, output hours, output minutes, output seconds,
                  output running, input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input running, output ready);
endinterface

FILE: hw/rtl/swlap_time.sv
// Time-of-day counter with run flag, clear and lap recall.
module swlap_time (
  input  logic             clk,
  input  logic             rst_n,
  input  swlap_pkg::cmd_t  cmd,
  input  swlap_pkg::time_t recall_time,
  output swlap_pkg::time_t time_q,
  output swlap_pkg::time_t time_nxt,
  output logic             run_q,
  output logic             run_nxt
);

  swlap_pkg::time_t time_r;
  logic             run_r;

  always_comb begin
    time_nxt = time_r;
    run_nxt  = run_r;
    if (cmd.tick && run_r) begin
      if (time_r.seconds >= swlap_pkg::SEC_LAST) begin
        time_nxt.seconds = '0;
        if (time_r.minutes >= swlap_pkg::MIN_LAST) begin
          time_nxt.minutes = '0;
          if (time_r.hours >= swlap_pkg::HOUR_LAST) begin
            time_nxt.hours = '0;
          end else begin
            time_nxt.hours = time_r.hours + 5'd1;
          end
        end else begin
          time_nxt.minutes = time_r.minutes + 6'd1;
        end
      end else begin
        time_nxt.seconds = time_r.seconds + 6'd1;
      end
    end
    if (cmd.toggle) begin
      run_nxt = ~run_r;
    end
    if (cmd.clr_all) begin
      time_nxt = '0;
    end
    // A recall only takes effect while the watch is paused.
    if (cmd.recall && !run_r) begin
      time_nxt = recall_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      run_r  <= 1'b0;
    end else begin
      time_r <= time_nxt;
      run_r  <= run_nxt;
    end
  end

  assign time_q = time_r;
  assign run_q  = run_r;

`ifndef SYNTH
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r.seconds <= swlap_pkg::SEC_LAST && time_r.minutes <= swlap_pkg::MIN_LAST &&
    time_r.hours <= swlap_pkg::HOUR_LAST)
    else $error("time counter out of range");

  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.toggle |=> run_r != $past(run_r))
    else $error("toggle did not flip run flag");
`endif

endmodule

FILE: hw/rtl/swlap_ring.sv
// Ring of stored lap times with head pointer and depth-relative read.
module swlap_ring #(
  parameter int LapDepth = swlap_pkg::LAP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swlap_pkg::cmd_t               cmd,
  input  swlap_pkg::time_t              cur_time,
  input  logic [swlap_pkg::DEPTH_W-1:0] recall_depth,
  output swlap_pkg::time_t              recall_time
);

  localparam int HeadW  = $clog2(LapDepth);
  localparam int DepthN = 2 ** swlap_pkg::DEPTH_W;

  swlap_pkg::time_t   lap_mem_r [LapDepth];
  logic [LapDepth-1:0] lap_vld_r;
  logic [HeadW-1:0]   head_r;
  logic [HeadW-1:0]   head_inc;
  logic [HeadW-1:0]   dmod_tab [DepthN];
  logic [HeadW-1:0]   dmod;
  logic [HeadW-1:0]   rd_idx;

  // Recall depth reduced modulo the ring size, one constant entry per code.
  for (genvar gi = 0; gi < DepthN; gi++) begin : g_dmod
    localparam int Mod = gi % LapDepth;
    assign dmod_tab[gi] = HeadW'(Mod);
  end

  assign dmod     = dmod_tab[recall_depth];
  assign head_inc = (head_r == HeadW'(LapDepth - 1)) ? '0 : head_r + 1'b1;
  // Wrapping in HeadW bits is harmless: the final index is below LapDepth.
  assign rd_idx   = head_r - dmod + ((head_r < dmod) ? HeadW'(LapDepth) : '0);
  assign recall_time = lap_vld_r[rd_idx] ? lap_mem_r[rd_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      lap_vld_r <= '0;
    end else if (cmd.clr_all || cmd.clr_laps) begin
      head_r    <= '0;
      lap_vld_r <= '0;
    end else if (cmd.store) begin
      head_r              <= head_inc;
      lap_vld_r[head_inc] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      lap_mem_r[head_inc] <= cur_time;
    end
  end

`ifndef SYNTH
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < HeadW'(LapDepth - 1) || head_r == HeadW'(LapDepth - 1))
    else $error("lap head outside ring");
`endif

endmodule

FILE: hw/rtl/stopwatch_with_lap_ring.sv
// Top level of the stopwatch with lap ring: channel registers and command decode.
//
// Use: every input word on in_ch carries a command kind (tick, toggle run,
// clear all, store lap, recall lap, clear laps) and a recall depth. Each
// accepted word produces exactly one output word on out_ch with the hours,
// minutes, seconds and run flag as they stand after that command.
// The word is first captured in an input register; when the output register
// is free, the counters, the lap ring and the output register are all
// updated by one pass of short logic. Throughput is one word per cycle while
// the receiver takes each result, limited only by the single output register;
// a word can be taken while the previous result still waits on out_ch.
// When the receiver stalls, the output word holds and the input register
// keeps its word; in_ch.ready drops once both are full and rises again in
// the cycle the receiver takes the result.
// Reset (rst_n low at a clock edge) empties both registers, zeroes the time,
// pauses the watch, moves the lap head to zero and marks every lap as zero.
module stopwatch_with_lap_ring #(
  parameter int LapDepth = swlap_pkg::LAP_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  swlap_in_if.sink    in_ch,
  swlap_out_if.source out_ch
);

  logic                          in_vld_r;
  logic [swlap_pkg::KIND_W-1:0]  in_kind_r;
  logic [swlap_pkg::DEPTH_W-1:0] in_depth_r;
  logic                          out_vld_r;
  swlap_pkg::time_t              out_time_r;
  logic                          out_run_r;

  logic             out_free;
  logic             step;
  swlap_pkg::cmd_t  cmd;
  swlap_pkg::time_t time_q;
  swlap_pkg::time_t time_nxt;
  swlap_pkg::time_t recall_time;
  logic             run_q;
  logic             run_nxt;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || step;

  always_comb begin
    cmd = '0;
    if (step) begin
      case (in_kind_r)
        swlap_pkg::KIND_TICK:     cmd.tick     = 1'b1;
        swlap_pkg::KIND_TOGGLE:   cmd.toggle   = 1'b1;
        swlap_pkg::KIND_CLR_ALL:  cmd.clr_all  = 1'b1;
        swlap_pkg::KIND_STORE:    cmd.store    = 1'b1;
        swlap_pkg::KIND_RECALL:   cmd.recall   = 1'b1;
        swlap_pkg::KIND_CLR_LAPS: cmd.clr_laps = 1'b1;
        default:                  cmd          = '0;
      endcase
    end
  end

  swlap_time u_time (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .recall_time (recall_time),
    .time_q      (time_q),
    .time_nxt    (time_nxt),
    .run_q       (run_q),
    .run_nxt     (run_nxt)
  );

  swlap_ring #(
    .LapDepth (LapDepth)
  ) u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cur_time     (time_q),
    .recall_depth (in_depth_r),
    .recall_time  (recall_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_kind_r  <= in_ch.kind;
      in_depth_r <= in_ch.recall_depth;
    end
    if (step) begin
      out_time_r <= time_nxt;
      out_run_r  <= run_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.hours   = out_time_r.hours;
  assign out_ch.minutes = out_time_r.minutes;
  assign out_ch.seconds = out_time_r.seconds;
  assign out_ch.running = out_run_r;

`ifndef SYNTH
  a_step_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r && out_run_r == run_q)
    else $error("step did not load an output word");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |=> in_vld_r && $stable(in_kind_r) && $stable(in_depth_r))
    else $error("waiting input word lost or changed");
`endif

endmodule
